/* rtl/bdq_pkg.sv */
// Package for the bounded deque with search.
// Holds request and status codes, sequencer states and field types.
// No dependencies.
package bdq_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 7;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LIMIT_W-1:0]  limit_t;

	localparam op_t OP_PUSH_BACK  = 3'd0;
	localparam op_t OP_PUSH_FRONT = 3'd1;
	localparam op_t OP_POP_BACK   = 3'd2;
	localparam op_t OP_POP_FRONT  = 3'd3;
	localparam op_t OP_READ_AT    = 3'd4;
	localparam op_t OP_CONTAINS   = 3'd5;
	localparam op_t OP_SIZE       = 3'd6;

	localparam status_t STS_OK    = 2'd0;
	localparam status_t STS_FULL  = 2'd1;
	localparam status_t STS_EMPTY = 2'd2;
	localparam status_t STS_RANGE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

/* rtl/bounded_deque_with_search_top.sv */
// Bounded double-ended queue of words with search, as a ring buffer.
// Steps: push, size and refused requests pass exec then done; a pop or read at that returns
// an entry adds a read step; contains adds scan and check per entry compared up to the first match.
// The next transaction is accepted once its result is valid; a held result holds the next.
// Reset clears head, occupancy, limit and control; the entry RAM is not cleared.
// Depends on bdq_pkg, bdq_unit and bdq_ram.
module bounded_deque_with_search_top #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  bdq_pkg::limit_t                      cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// value, position
	input  logic [((WORD_BITS+bdq_pkg::POS_W+7)/8)*8-1:0]   s_axis_tdata,
	// op
	input  bdq_pkg::op_t                         s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// data, count
	output logic [((WORD_BITS+bdq_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata,
	// found, status
	output logic [bdq_pkg::STATUS_W:0]           m_axis_tuser
);

	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH+1);
	localparam int LW        = (CNT_W > bdq_pkg::LIMIT_W) ? CNT_W : bdq_pkg::LIMIT_W;
	localparam int PW        = (CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W;
	localparam int OUT_TD_W  = ((WORD_BITS+bdq_pkg::COUNT_W+7)/8)*8;

	bdq_pkg::state_t  state_q, state_d;
	bdq_pkg::limit_t  lim_q;
	bdq_pkg::op_t     op_q;
	bdq_pkg::pos_t    pos_q;
	bdq_pkg::status_t status_q;
	logic [WORD_BITS-1:0] val_q;
	logic [WORD_BITS-1:0] data_q;
	logic                 found_q;
	logic [ADDR_W-1:0]    head_q;
	logic [CNT_W-1:0]     occ_q;
	logic [ADDR_W-1:0]    idx_q;

	logic                 m_valid_q;
	logic [WORD_BITS-1:0] m_data_q;
	logic                 m_found_q;
	bdq_pkg::count_t      m_count_q;
	bdq_pkg::status_t     m_status_q;

	logic [ADDR_W-1:0]    unit_off;
	logic [ADDR_W-1:0]    unit_slot;
	logic                 unit_eq;
	logic                 ram_we, ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [LW-1:0] lim_eff;
	logic          is_full, is_empty, pos_bad, scan_last, move_out;

	always_comb begin
		if (lim_q == '0 || LW'(lim_q) > LW'(DEPTH)) begin
			lim_eff = LW'(DEPTH);
		end else begin
			lim_eff = LW'(lim_q);
		end
	end

	assign is_full   = (LW'(occ_q) >= lim_eff);
	assign is_empty  = (occ_q == '0);
	assign pos_bad   = (PW'(pos_q) >= PW'(occ_q));
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) >= occ_q);
	assign move_out  = (state_q == bdq_pkg::S_DONE) && (!m_valid_q || m_axis_tready);

	bdq_unit #(
		.DEPTH    (DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_unit (
		.base  (head_q),
		.offset(unit_off),
		.slot  (unit_slot),
		.cmp_a (ram_rdata),
		.cmp_b (val_q),
		.equal (unit_eq)
	);

	bdq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(unit_slot),
		.wdata(val_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = bdq_pkg::S_EXEC;
				end
			end
			bdq_pkg::S_EXEC: begin
				case (op_q) inside
					bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT: begin
						state_d = is_empty ? bdq_pkg::S_DONE : bdq_pkg::S_READ;
					end
					bdq_pkg::OP_READ_AT: begin
						state_d = pos_bad ? bdq_pkg::S_DONE : bdq_pkg::S_READ;
					end
					bdq_pkg::OP_CONTAINS: begin
						state_d = is_empty ? bdq_pkg::S_DONE : bdq_pkg::S_SCAN;
					end
					default: begin
						state_d = bdq_pkg::S_DONE;
					end
				endcase
			end
			bdq_pkg::S_READ: begin
				state_d = bdq_pkg::S_DONE;
			end
			bdq_pkg::S_SCAN: begin
				state_d = bdq_pkg::S_CHECK;
			end
			bdq_pkg::S_CHECK: begin
				state_d = (unit_eq || scan_last) ? bdq_pkg::S_DONE : bdq_pkg::S_SCAN;
			end
			bdq_pkg::S_DONE: begin
				if (move_out) begin
					state_d = bdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bdq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		unit_off  = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = unit_slot;
		unique case (state_q)
			bdq_pkg::S_EXEC: begin
				unique case (op_q)
					bdq_pkg::OP_PUSH_BACK: begin
						unit_off = ADDR_W'(occ_q);
						ram_we   = !is_full;
					end
					bdq_pkg::OP_PUSH_FRONT: begin
						unit_off = ADDR_W'(DEPTH-1);
						ram_we   = !is_full;
					end
					bdq_pkg::OP_POP_BACK: begin
						unit_off = ADDR_W'(occ_q - CNT_W'(1));
						ram_re   = !is_empty;
					end
					bdq_pkg::OP_POP_FRONT: begin
						unit_off  = ADDR_W'(1);
						ram_raddr = head_q;
						ram_re    = !is_empty;
					end
					bdq_pkg::OP_READ_AT: begin
						unit_off = ADDR_W'(pos_q);
						ram_re   = !pos_bad;
					end
					default: begin
						unit_off = '0;
					end
				endcase
			end
			bdq_pkg::S_SCAN: begin
				unit_off = idx_q;
				ram_re   = 1'b1;
			end
			default: begin
				unit_off = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bdq_pkg::S_IDLE;
			lim_q     <= '0;
			head_q    <= '0;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (state_q == bdq_pkg::S_EXEC) begin
				unique case (op_q)
					bdq_pkg::OP_PUSH_BACK: begin
						if (!is_full) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end
					bdq_pkg::OP_PUSH_FRONT: begin
						if (!is_full) begin
							head_q <= unit_slot;
							occ_q  <= occ_q + CNT_W'(1);
						end
					end
					bdq_pkg::OP_POP_BACK: begin
						if (!is_empty) begin
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					bdq_pkg::OP_POP_FRONT: begin
						if (!is_empty) begin
							head_q <= unit_slot;
							occ_q  <= occ_q - CNT_W'(1);
						end
					end
					default: begin
						occ_q <= occ_q;
					end
				endcase
			end
			if (move_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					op_q     <= s_axis_tuser;
					val_q    <= s_axis_tdata[WORD_BITS-1:0];
					pos_q    <= s_axis_tdata[WORD_BITS +: bdq_pkg::POS_W];
					data_q   <= '0;
					found_q  <= 1'b0;
					status_q <= bdq_pkg::STS_OK;
					idx_q    <= '0;
				end
			end
			bdq_pkg::S_EXEC: begin
				case (op_q) inside
					bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT: begin
						if (is_full) begin
							status_q <= bdq_pkg::STS_FULL;
						end
					end
					bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT: begin
						if (is_empty) begin
							status_q <= bdq_pkg::STS_EMPTY;
						end
					end
					bdq_pkg::OP_READ_AT: begin
						if (pos_bad) begin
							status_q <= bdq_pkg::STS_RANGE;
						end
					end
					default: begin
						status_q <= status_q;
					end
				endcase
			end
			bdq_pkg::S_READ: begin
				data_q <= ram_rdata;
			end
			bdq_pkg::S_CHECK: begin
				if (unit_eq) begin
					found_q <= 1'b1;
				end
				idx_q <= idx_q + ADDR_W'(1);
			end
			bdq_pkg::S_DONE: begin
				if (move_out) begin
					m_data_q   <= data_q;
					m_found_q  <= found_q;
					m_count_q  <= bdq_pkg::count_t'(occ_q);
					m_status_q <= status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign s_axis_tready = (state_q == bdq_pkg::S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TD_W'({m_count_q, m_data_q});
	assign m_axis_tuser  = {m_status_q, m_found_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == bdq_pkg::S_EXEC))
		else $error("accepted transaction did not start execution");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("entry RAM written and read in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		move_out |=> (m_valid_q && m_count_q == bdq_pkg::count_t'(occ_q)))
		else $error("result count differs from occupancy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdq_pkg::S_DONE && found_q) |-> (op_q == bdq_pkg::OP_CONTAINS))
		else $error("found flag set outside a search");

endmodule

/* rtl/bdq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bdq_unit.sv */
// Shared unit of the deque sequencer: ring slot arithmetic and word compare.
// No dependencies.
module bdq_unit #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic [$clog2(DEPTH)-1:0] base,
	input  logic [$clog2(DEPTH)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0] slot,
	input  logic [WORD_BITS-1:0]     cmp_a,
	input  logic [WORD_BITS-1:0]     cmp_b,
	output logic                     equal
);

	localparam int ADDR_W = $clog2(DEPTH);

	logic [ADDR_W:0] sum;

	always_comb begin
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (ADDR_W+1)'(DEPTH)) begin
			sum = sum - (ADDR_W+1)'(DEPTH);
		end
	end

	assign slot  = sum[ADDR_W-1:0];
	assign equal = (cmp_a == cmp_b);

endmodule
